FILE: rtl/core/hlpd_pkg.sv
// ----------------------------------------------------------------------------
// hlpd_pkg
// Constants shared by the Hough line point distance unit: fixed-point angle
// constants, saturation limits, Taylor reciprocals and iteration counts.
// ----------------------------------------------------------------------------
package hlpd_pkg;

	localparam int COORD_BITS_DEF = 12;

	// angle codes and Q.30 angles
	localparam logic [14:0] THETA_CODE_1_57 = 15'd12861;
	localparam logic [31:0] HALF_PI_Q30     = 32'd1686629713;
	localparam logic [32:0] PI_Q30          = 33'd3373259426;

	// result limits
	localparam logic [12:0] DIST_MAX       = 13'd8191;
	localparam logic [13:0] SHORT_LEG_SAT  = 14'd11586;
	localparam logic [31:0] LONG_LEG_CLAMP = 32'h8000_0000;

	// taylor series for sin on a quarter turn
	localparam int TAYLOR_TERMS = 6;
	localparam int RECIP_SHIFT  = 41;
	localparam int RECIP_LO_W   = 20;

	// ceil(2^41 / ((2k)(2k+1))) for k = 1..6
	localparam logic [38:0] RECIP [TAYLOR_TERMS] = '{
		39'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6),
		39'(((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20),
		39'(((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42),
		39'(((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72),
		39'(((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110),
		39'(((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156)
	};

	// iteration counts
	localparam int DIV_QBITS   = 34;
	localparam int DIV2_QBITS  = 27;
	localparam int SQRT_STEPS  = 14;

endpackage

FILE: rtl/core/hough_line_point_distance_unit.sv
// ----------------------------------------------------------------------------
// hough_line_point_distance_unit
// Whole-pixel distance from a point to a Hough normal-form line, one point per
// clock unless stalled, through a pipeline of 104 stages. sin and cos come from
// two parallel Taylor lanes (19 stages), the line's row and column from two
// restoring dividers with one quotient bit per stage (34 stages), the triangle
// height from a 27-stage divider and a 14-stage square root. The unit takes a
// new request every cycle while the result side keeps up; a stalled result
// holds the whole pipeline, so the request side is stalled in the same cycle.
// Every request gives exactly one result.
// ----------------------------------------------------------------------------
module hough_line_point_distance_unit import hlpd_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  point_valid,
	output logic                  point_stall,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	input  logic [14:0]           angle_theta,
	input  logic signed [16:0]    offset_rho,
	output logic                  dist_valid,
	input  logic                  dist_stall,
	output logic [12:0]           distance
);

	localparam int CB     = COORD_BITS;
	localparam int MAG_W  = ((CB + 31) > 42 ? (CB + 31) : 42) + 1;
	localparam int NUM_W  = MAG_W + 1;
	localparam int FW     = ((CB + 5) > 17 ? (CB + 5) : 17) + 1;
	localparam int TRIG_N = 1 + 3 * TAYLOR_TERMS;

	localparam int P_TRIG = 1;
	localparam int P_SC   = P_TRIG + TRIG_N;
	localparam int P_NUM  = P_SC + 1;
	localparam int P_DIV  = P_NUM + 1;
	localparam int P_LEG  = P_DIV + DIV_QBITS + 1;
	localparam int P_MM   = P_LEG + 1;
	localparam int P_SQ   = P_MM + 1;
	localparam int P_DIV2 = P_SQ + 1;
	localparam int P_SQRT = P_DIV2 + DIV2_QBITS + 1;
	localparam int P_OUT  = P_SQRT + SQRT_STEPS + 1;
	localparam int NST    = P_OUT + 1;

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [14:0]   theta;
		logic [16:0]   rho;
	} point_t;

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [16:0]   rho;
		logic          fin;
		logic [12:0]   fin_val;
	} side_t;

	typedef struct packed {
		logic [31:0] x2;
		logic [32:0] term;
		logic [32:0] v;
		logic [52:0] plo;
		logic [51:0] phi;
		logic [33:0] sum;
	} lane_t;

	typedef struct packed {
		side_t       side;
		logic        neg_s;
		logic        neg_c;
		lane_t [1:0] ln;
	} trig_t;

	typedef struct packed {
		side_t       side;
		logic [32:0] s;
		logic [32:0] c;
	} sc_t;

	typedef struct packed {
		side_t            side;
		logic [NUM_W-1:0] ny;
		logic [NUM_W-1:0] nx;
		logic [32:0]      s;
		logic [32:0]      c;
	} num_t;

	typedef struct packed {
		logic [MAG_W-1:0]     rem;
		logic [31:0]          d;
		logic [DIV_QBITS-1:0] q;
		logic                 neg;
		logic                 zero;
		logic                 sat;
	} dlane_t;

	typedef struct packed {
		side_t        side;
		dlane_t [1:0] ln;
	} div_t;

	typedef struct packed {
		side_t       side;
		logic [34:0] a;
		logic [34:0] b;
	} leg_t;

	typedef struct packed {
		side_t       side;
		logic [13:0] m;
		logic [31:0] mm;
	} mm_t;

	typedef struct packed {
		side_t       side;
		logic [27:0] m2;
		logic [62:0] mm2;
	} sq_t;

	typedef struct packed {
		side_t                 side;
		logic [27:0]           m2;
		logic [53:0]           rem;
		logic [62:0]           den;
		logic [DIV2_QBITS-1:0] q;
	} div2_t;

	typedef struct packed {
		side_t       side;
		logic [27:0] v;
		logic [27:0] res;
	} sqrt_t;

	logic           adv;
	logic [NST-1:0] vld_s;
	point_t         pt_s1;
	trig_t          trig_s [TRIG_N];
	trig_t          trig_first;
	sc_t            sc_s;
	sc_t            sc_nxt;
	num_t           num_s;
	num_t           num_nxt;
	div_t           div_s [DIV_QBITS + 1];
	div_t           div_first;
	leg_t           leg_s;
	leg_t           leg_nxt;
	mm_t            mm_s;
	mm_t            mm_nxt;
	sq_t            sq_s;
	sq_t            sq_nxt;
	div2_t          div2_s [DIV2_QBITS + 1];
	div2_t          div2_first;
	sqrt_t          sqrt_s [SQRT_STEPS + 1];
	sqrt_t          sqrt_first;
	logic [27:0]    r_fix;
	logic [12:0]    dist_s;
	logic [12:0]    dist_nxt;

	// one enable for the whole pipe: it moves unless a finished result waits
	assign adv         = !(dist_valid && dist_stall);
	assign point_stall = !adv;
	assign dist_valid  = vld_s[NST-1];
	assign distance    = dist_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], point_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s1.x     <= point_x;
			pt_s1.y     <= point_y;
			pt_s1.theta <= angle_theta;
			pt_s1.rho   <= offset_rho;
		end
	end

	// quadrant reflection, special angles, taylor seeds
	always_comb begin
		logic [31:0]          t;
		logic [31:0]          uq;
		logic [30:0]          us;
		logic [30:0]          uc;
		logic                 ns;
		logic                 nc;
		logic [CB-1:0]        coord;
		logic signed [FW-1:0] dif;
		logic [FW-1:0]        dmag;
		logic [FW-1:0]        dsh;
		logic [61:0]          sq0;
		logic [61:0]          sq1;
		t  = {pt_s1.theta, 17'd0};
		uq = '0;
		priority if (t <= HALF_PI_Q30) begin
			us = t[30:0];
			uc = 31'(HALF_PI_Q30 - t);
			ns = 1'b0;
			nc = 1'b0;
		end else if ({1'b0, t} <= PI_Q30) begin
			uq = t - HALF_PI_Q30;
			us = 31'(HALF_PI_Q30 - uq);
			uc = uq[30:0];
			ns = 1'b0;
			nc = 1'b1;
		end else begin
			uq = t - PI_Q30[31:0];
			us = uq[30:0];
			uc = 31'(HALF_PI_Q30 - uq);
			ns = 1'b1;
			nc = 1'b1;
		end
		coord = (pt_s1.theta == '0) ? pt_s1.x : pt_s1.y;
		dif   = $signed(FW'({coord, 4'b0000})) - FW'($signed(pt_s1.rho));
		dmag  = dif[FW-1] ? FW'(-dif) : FW'(dif);
		dsh   = dmag >> 4;
		sq0   = us * us;
		sq1   = uc * uc;

		trig_first              = '0;
		trig_first.side.x       = pt_s1.x;
		trig_first.side.y       = pt_s1.y;
		trig_first.side.rho     = pt_s1.rho;
		trig_first.side.fin     = (pt_s1.theta == '0) || (pt_s1.theta == THETA_CODE_1_57);
		trig_first.side.fin_val = (dsh > FW'(DIST_MAX)) ? DIST_MAX : dsh[12:0];
		trig_first.neg_s        = ns;
		trig_first.neg_c        = nc;
		trig_first.ln[0].x2     = sq0[61:30];
		trig_first.ln[0].term   = {2'b00, us};
		trig_first.ln[0].sum    = {3'b000, us};
		trig_first.ln[1].x2     = sq1[61:30];
		trig_first.ln[1].term   = {2'b00, uc};
		trig_first.ln[1].sum    = {3'b000, uc};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trig_s[0] <= trig_first;
		end
	end

	// each taylor term: multiply by x^2, multiply by reciprocal, accumulate
	for (genvar j = 1; j < TRIG_N; j++) begin : g_trig
		localparam int KI = (j - 1) / 3;
		localparam int PH = (j - 1) % 3;
		trig_t nxt;

		if (PH == 0) begin : g_sq
			always_comb begin
				logic [64:0] p;
				nxt = trig_s[j-1];
				for (int l = 0; l < 2; l++) begin
					p            = trig_s[j-1].ln[l].term * trig_s[j-1].ln[l].x2;
					nxt.ln[l].v  = p[62:30];
				end
			end
		end else if (PH == 1) begin : g_rcp
			always_comb begin
				nxt = trig_s[j-1];
				for (int l = 0; l < 2; l++) begin
					nxt.ln[l].plo = trig_s[j-1].ln[l].v * RECIP[KI][RECIP_LO_W-1:0];
					nxt.ln[l].phi = trig_s[j-1].ln[l].v * RECIP[KI][38:RECIP_LO_W];
				end
			end
		end else begin : g_acc
			always_comb begin
				logic [71:0] full;
				logic [30:0] q;
				nxt = trig_s[j-1];
				for (int l = 0; l < 2; l++) begin
					full           = {trig_s[j-1].ln[l].phi, 20'd0} + 72'(trig_s[j-1].ln[l].plo);
					q              = full[71:RECIP_SHIFT];
					nxt.ln[l].term = {2'b00, q};
					// the x^3, x^7 and x^11 terms subtract, the x^5, x^9 and x^13 terms add
					if ((KI % 2) == 0) begin
						nxt.ln[l].sum = trig_s[j-1].ln[l].sum - {3'b000, q};
					end else begin
						nxt.ln[l].sum = trig_s[j-1].ln[l].sum + {3'b000, q};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				trig_s[j] <= nxt;
			end
		end
	end

	// clamp and sign the sums
	always_comb begin
		logic [31:0] ms;
		logic [31:0] mc;
		ms          = trig_s[TRIG_N-1].ln[0].sum[33] ? '0 : trig_s[TRIG_N-1].ln[0].sum[31:0];
		mc          = trig_s[TRIG_N-1].ln[1].sum[33] ? '0 : trig_s[TRIG_N-1].ln[1].sum[31:0];
		sc_nxt.side = trig_s[TRIG_N-1].side;
		sc_nxt.s    = trig_s[TRIG_N-1].neg_s ? (33'd0 - {1'b0, ms}) : {1'b0, ms};
		sc_nxt.c    = trig_s[TRIG_N-1].neg_c ? (33'd0 - {1'b0, mc}) : {1'b0, mc};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s <= sc_nxt;
		end
	end

	// numerators rho*2^26 - x*c and rho*2^26 - y*s
	always_comb begin
		logic signed [NUM_W-1:0] p30;
		logic signed [CB+33:0]   xc;
		logic signed [CB+33:0]   ys;
		p30          = NUM_W'($signed(sc_s.side.rho)) <<< 26;
		xc           = $signed({1'b0, sc_s.side.x}) * $signed(sc_s.c);
		ys           = $signed({1'b0, sc_s.side.y}) * $signed(sc_s.s);
		num_nxt.side = sc_s.side;
		num_nxt.ny   = p30 - NUM_W'(xc);
		num_nxt.nx   = p30 - NUM_W'(ys);
		num_nxt.s    = sc_s.s;
		num_nxt.c    = sc_s.c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s <= num_nxt;
		end
	end

	// divider setup: magnitudes, quotient sign, zero divisor, overflow
	always_comb begin
		logic [NUM_W-1:0] n [2];
		logic [32:0]      d [2];
		logic [MAG_W-1:0] nm;
		logic [31:0]      dm;
		n[0] = num_s.ny;
		n[1] = num_s.nx;
		d[0] = num_s.s;
		d[1] = num_s.c;
		div_first      = '0;
		div_first.side = num_s.side;
		for (int l = 0; l < 2; l++) begin
			nm = n[l][NUM_W-1] ? MAG_W'(-n[l]) : MAG_W'(n[l]);
			dm = d[l][32] ? 32'(-d[l]) : d[l][31:0];
			div_first.ln[l].rem  = nm;
			div_first.ln[l].d    = dm;
			div_first.ln[l].neg  = n[l][NUM_W-1] ^ d[l][32];
			div_first.ln[l].zero = (d[l] == '0);
			div_first.ln[l].sat  = (nm >> DIV_QBITS) >= MAG_W'(dm);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= div_first;
		end
	end

	for (genvar j = 1; j <= DIV_QBITS; j++) begin : g_div
		localparam int BI = DIV_QBITS - j;
		div_t nxt;

		always_comb begin
			nxt = div_s[j-1];
			for (int l = 0; l < 2; l++) begin
				if ((div_s[j-1].ln[l].rem >> BI) >= MAG_W'(div_s[j-1].ln[l].d)) begin
					nxt.ln[l].rem   = div_s[j-1].ln[l].rem - (MAG_W'(div_s[j-1].ln[l].d) << BI);
					nxt.ln[l].q[BI] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[j] <= nxt;
			end
		end
	end

	// truncated row and column, then legs against the point
	always_comb begin
		logic [34:0] qm [2];
		logic [35:0] ql;
		logic [35:0] dif;
		logic [34:0] leg [2];
		for (int l = 0; l < 2; l++) begin
			priority if (div_s[DIV_QBITS].ln[l].zero) begin
				qm[l] = '0;
			end else if (div_s[DIV_QBITS].ln[l].sat) begin
				qm[l] = 35'd1 << DIV_QBITS;
			end else begin
				qm[l] = {1'b0, div_s[DIV_QBITS].ln[l].q};
			end
			ql = div_s[DIV_QBITS].ln[l].neg ? (36'd0 - {1'b0, qm[l]}) : {1'b0, qm[l]};
			if (l == 0) begin
				dif = ql - 36'(div_s[DIV_QBITS].side.y);
			end else begin
				dif = ql - 36'(div_s[DIV_QBITS].side.x);
			end
			leg[l] = dif[35] ? 35'(36'd0 - dif) : dif[34:0];
		end
		leg_nxt.side = div_s[DIV_QBITS].side;
		leg_nxt.a    = leg[0];
		leg_nxt.b    = leg[1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			leg_s <= leg_nxt;
		end
	end

	// short and long leg, degenerate and saturating triangles
	always_comb begin
		logic [34:0] m;
		logic [34:0] mm;
		m      = (leg_s.a < leg_s.b) ? leg_s.a : leg_s.b;
		mm     = (leg_s.a < leg_s.b) ? leg_s.b : leg_s.a;
		mm_nxt.side = leg_s.side;
		if (!leg_s.side.fin) begin
			if (m == '0) begin
				mm_nxt.side.fin     = 1'b1;
				mm_nxt.side.fin_val = '0;
			end else if (m >= 35'(SHORT_LEG_SAT)) begin
				mm_nxt.side.fin     = 1'b1;
				mm_nxt.side.fin_val = DIST_MAX;
			end
		end
		mm_nxt.m  = m[13:0];
		mm_nxt.mm = (mm > 35'(LONG_LEG_CLAMP)) ? LONG_LEG_CLAMP : mm[31:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mm_s <= mm_nxt;
		end
	end

	always_comb begin
		logic [63:0] p;
		p           = mm_s.mm * mm_s.mm;
		sq_nxt.side = mm_s.side;
		sq_nxt.m2   = 28'(mm_s.m) * 28'(mm_s.m);
		sq_nxt.mm2  = p[62:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s <= sq_nxt;
		end
	end

	// m^4 over m^2 + M^2
	always_comb begin
		logic [55:0] p;
		p               = sq_s.m2 * sq_s.m2;
		div2_first.side = sq_s.side;
		div2_first.m2   = sq_s.m2;
		div2_first.rem  = p[53:0];
		div2_first.den  = 63'(sq_s.m2) + sq_s.mm2;
		div2_first.q    = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div2_s[0] <= div2_first;
		end
	end

	for (genvar j = 1; j <= DIV2_QBITS; j++) begin : g_div2
		localparam int BI = DIV2_QBITS - j;
		div2_t nxt;

		always_comb begin
			nxt = div2_s[j-1];
			if ((div2_s[j-1].rem >> BI) >= div2_s[j-1].den) begin
				nxt.rem   = div2_s[j-1].rem - 54'(div2_s[j-1].den << BI);
				nxt.q[BI] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div2_s[j] <= nxt;
			end
		end
	end

	// round the quotient up, square of the height
	always_comb begin
		r_fix           = 28'(div2_s[DIV2_QBITS].q) + 28'(div2_s[DIV2_QBITS].rem != '0);
		sqrt_first.side = div2_s[DIV2_QBITS].side;
		sqrt_first.v    = div2_s[DIV2_QBITS].m2 - r_fix;
		sqrt_first.res  = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqrt_s[0] <= sqrt_first;
		end
	end

	for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
		localparam logic [27:0] ONE = 28'd1 << (2 * (SQRT_STEPS - j));
		sqrt_t nxt;

		always_comb begin
			logic [28:0] trial;
			nxt   = sqrt_s[j-1];
			trial = {1'b0, sqrt_s[j-1].res} + {1'b0, ONE};
			if ({1'b0, sqrt_s[j-1].v} >= trial) begin
				nxt.v   = sqrt_s[j-1].v - trial[27:0];
				nxt.res = (sqrt_s[j-1].res >> 1) + ONE;
			end else begin
				nxt.res = sqrt_s[j-1].res >> 1;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sqrt_s[j] <= nxt;
			end
		end
	end

	always_comb begin
		if (sqrt_s[SQRT_STEPS].side.fin) begin
			dist_nxt = sqrt_s[SQRT_STEPS].side.fin_val;
		end else if (sqrt_s[SQRT_STEPS].res > 28'(DIST_MAX)) begin
			dist_nxt = DIST_MAX;
		end else begin
			dist_nxt = sqrt_s[SQRT_STEPS].res[12:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dist_s <= dist_nxt;
		end
	end

	// a divider that neither overflowed nor saw a zero divisor ends below it
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[P_DIV+DIV_QBITS] |->
			(div_s[DIV_QBITS].ln[0].sat || div_s[DIV_QBITS].ln[0].zero ||
			 (div_s[DIV_QBITS].ln[0].rem < MAG_W'(div_s[DIV_QBITS].ln[0].d))) &&
			(div_s[DIV_QBITS].ln[1].sat || div_s[DIV_QBITS].ln[1].zero ||
			 (div_s[DIV_QBITS].ln[1].rem < MAG_W'(div_s[DIV_QBITS].ln[1].d))))
		else $error("row/column divider remainder not below divisor");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[P_DIV2] && !div2_s[0].side.fin |-> div2_s[0].den != '0)
		else $error("zero hypotenuse reached the height divider");

	a_ceil_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[P_DIV2+DIV2_QBITS] && !div2_s[DIV2_QBITS].side.fin |->
			r_fix <= div2_s[DIV2_QBITS].m2)
		else $error("rounded quotient exceeds short leg squared");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[P_SQRT+SQRT_STEPS] && !sqrt_s[SQRT_STEPS].side.fin |->
			sqrt_s[SQRT_STEPS].res < 28'(SHORT_LEG_SAT))
		else $error("height above short leg bound");

endmodule
